### src/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and constants of the skip-list link patcher: field widths,
// configuration register indexes and reset values, and the sequencer states.
// ----------------------------------------------------------------------------
package slp_pkg;

   // record index field and the long-division digit size
   localparam int INDEX_BITS  = 48;
   localparam int DIGIT_BITS  = 8;
   localparam int DIV_CYCLES  = INDEX_BITS / DIGIT_BITS;
   localparam int DCNT_W      = $clog2(DIV_CYCLES);

   // configuration register widths
   localparam int STEP_BITS      = 9;
   localparam int LIMIT_BITS     = 5;
   localparam int LWIDTH_BITS    = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_UNIT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINK_WIDTH  = 2'd2;

   // reset values
   localparam logic [STEP_BITS-1:0]   STEP_RESET   = 9'd4;
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 5'd10;
   localparam logic [LWIDTH_BITS-1:0] LWIDTH_RESET = 3'd4;

   // legal ranges of the step unit and link width
   localparam logic [STEP_BITS-1:0]   STEP_MIN   = 9'd2;
   localparam logic [STEP_BITS-1:0]   STEP_MAX   = 9'd256;
   localparam logic [LWIDTH_BITS-1:0] LWIDTH_MIN = 3'd1;
   localparam logic [LWIDTH_BITS-1:0] LWIDTH_MAX = 3'd6;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_EMIT
   } state_type;

endpackage

### src/skip_list_link_patcher_core.sv
// ----------------------------------------------------------------------------
// skip_list_link_patcher_core
// Takes the index and file offset of a newly appended skip-list record and
// returns the link writes that patch earlier records to point at it. The
// record's level comes from repeated division of its index by the step unit;
// one shared long-division unit retires 8 quotient bits a cycle. Division
// stops at the level limit or at the first division that leaves a remainder,
// and the walk then visits each level of the table below the record's level.
// Results leave through an output register; the walk stalls while it is full.
// One item is worked on at a time, and req_ready is high only when the block
// is between items. An item with no link write returns one empty result.
// ----------------------------------------------------------------------------
module skip_list_link_patcher_core
   import slp_pkg::*;
#(
   parameter int MAX_LEVELS  = 16,
   parameter int OFFSET_BITS = 48
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [INDEX_BITS-1:0]     req_record_index,
   input  logic [OFFSET_BITS-1:0]    req_record_offset,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_write_valid,
   output logic [OFFSET_BITS-1:0]    rsp_write_address,
   output logic [OFFSET_BITS-1:0]    rsp_write_data,
   output logic                      rsp_last
);

   localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
   localparam int IDX_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int LINK_OFS_W = LVL_W + LWIDTH_BITS;
   localparam int REM_W      = STEP_BITS - 1;

   // configuration registers
   logic [STEP_BITS-1:0]   step_ff;
   logic [LIMIT_BITS-1:0]  limit_ff;
   logic [LWIDTH_BITS-1:0] lwidth_ff;

   logic [STEP_BITS-1:0]   step_eff;
   logic [LVL_W-1:0]       lim_eff;
   logic [LWIDTH_BITS-1:0] lw_eff;
   logic [LIMIT_BITS:0]    lim_wide;

   // sequencer and divider
   state_type              state_ff, state_in;
   logic [INDEX_BITS-1:0]  div_ff, div_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [DCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic [LVL_W-1:0]       level_ff, level_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic [LINK_OFS_W-1:0]  link_ofs_ff, link_ofs_in;
   logic                   sent_ff, sent_in;
   logic [OFFSET_BITS-1:0] ofs_ff, ofs_in;

   logic [REM_W-1:0]       rem_next;
   logic [DIGIT_BITS-1:0]  qbits;

   // last offset per level; nz_ff marks levels holding a nonzero offset
   logic [OFFSET_BITS-1:0] table_ff [MAX_LEVELS];
   logic [MAX_LEVELS-1:0]  nz_ff, nz_in;
   logic [MAX_LEVELS-1:0]  below_mask, later_mask;
   logic                   do_store;
   logic [IDX_W-1:0]       lvl_idx;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_wv_ff, rsp_wv_in;
   logic [OFFSET_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic [OFFSET_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   out_free;

   // ------------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET;
         limit_ff  <= LIMIT_RESET;
         lwidth_ff <= LWIDTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_UNIT:   step_ff   <= csr_data;
            CSR_LEVEL_LIMIT: limit_ff  <= csr_data[LIMIT_BITS-1:0];
            CSR_LINK_WIDTH:  lwidth_ff <= csr_data[LWIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (step_ff < STEP_MIN) begin
         step_eff = STEP_MIN;
      end else if (step_ff > STEP_MAX) begin
         step_eff = STEP_MAX;
      end else begin
         step_eff = step_ff;
      end

      if ({1'b0, limit_ff} > (LIMIT_BITS+1)'(MAX_LEVELS)) begin
         lim_wide = (LIMIT_BITS+1)'(MAX_LEVELS);
      end else begin
         lim_wide = {1'b0, limit_ff};
      end
      lim_eff = LVL_W'(lim_wide);

      if (lwidth_ff < LWIDTH_MIN) begin
         lw_eff = LWIDTH_MIN;
      end else if (lwidth_ff > LWIDTH_MAX) begin
         lw_eff = LWIDTH_MAX;
      end else begin
         lw_eff = lwidth_ff;
      end
   end

   // ------------------------------------------------------------------------
   // long division, one digit of the dividend per cycle
   // ------------------------------------------------------------------------
   always_comb begin
      logic [REM_W:0]   t;
      logic [REM_W-1:0] r;
      r = rem_ff;
      qbits = '0;
      for (int k = 0; k < DIGIT_BITS; k++) begin
         t = {r, div_ff[INDEX_BITS-1-k]};
         if (t >= step_eff) begin
            t = t - step_eff;
            qbits[DIGIT_BITS-1-k] = 1'b1;
         end
         r = t[REM_W-1:0];
      end
      rem_next = r;
   end

   // ------------------------------------------------------------------------
   // level masks for the table walk
   // ------------------------------------------------------------------------
   always_comb begin
      for (int j = 0; j < MAX_LEVELS; j++) begin
         below_mask[j] = (LVL_W'(j) < level_ff);
         later_mask[j] = (LVL_W'(j) > lvl_ff) && (LVL_W'(j) < level_ff);
      end
   end

   assign lvl_idx  = lvl_ff[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      level_ff    <= level_in;
      lvl_ff      <= lvl_in;
      link_ofs_ff <= link_ofs_in;
      sent_ff     <= sent_in;
      ofs_ff      <= ofs_in;
      rsp_wv_ff   <= rsp_wv_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_LEVELS; j++) begin
         if (do_store && below_mask[j]) begin
            table_ff[j] <= ofs_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      level_in     = level_ff;
      lvl_in       = lvl_ff;
      link_ofs_in  = link_ofs_ff;
      sent_in      = sent_ff;
      ofs_in       = ofs_ff;
      nz_in        = nz_ff;
      do_store     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_wv_in    = rsp_wv_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               div_in      = req_record_index;
               ofs_in      = req_record_offset;
               rem_in      = '0;
               dcnt_in     = '0;
               level_in    = '0;
               lvl_in      = '0;
               link_ofs_in = '0;
               sent_in     = 1'b0;
               state_in    = (lim_eff == '0) ? S_EMIT : S_DIVIDE;
            end
         end

         S_DIVIDE: begin
            div_in  = {div_ff[INDEX_BITS-DIGIT_BITS-1:0], qbits};
            rem_in  = rem_next;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_CYCLES - 1)) begin
               rem_in  = '0;
               dcnt_in = '0;
               if (rem_next == '0) begin
                  // divides evenly: one more level, keep dividing the quotient up to the limit
                  level_in = level_ff + 1'b1;
                  if (level_ff + 1'b1 == lim_eff) begin
                     state_in = S_EMIT;
                  end
               end else begin
                  state_in = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            if (lvl_ff < level_ff) begin
               // a past record at a level below ours always reaches one more
               // level, so each of these levels holding a nonzero offset gets patched
               if (nz_ff[lvl_idx]) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_wv_in    = 1'b1;
                     rsp_addr_in  = table_ff[lvl_idx] + OFFSET_BITS'(1)
                                    + OFFSET_BITS'(link_ofs_ff);
                     rsp_data_in  = ofs_ff;
                     rsp_last_in  = ~|(nz_ff & later_mask);
                     sent_in      = 1'b1;
                     lvl_in       = lvl_ff + 1'b1;
                     link_ofs_in  = link_ofs_ff + LINK_OFS_W'(lw_eff);
                  end
               end else begin
                  lvl_in      = lvl_ff + 1'b1;
                  link_ofs_in = link_ofs_ff + LINK_OFS_W'(lw_eff);
               end
            end else if (sent_ff || out_free) begin
               if (!sent_ff) begin
                  // empty completion
                  rsp_valid_in = 1'b1;
                  rsp_wv_in    = 1'b0;
                  rsp_addr_in  = '0;
                  rsp_data_in  = '0;
                  rsp_last_in  = 1'b1;
               end
               do_store = 1'b1;
               for (int j = 0; j < MAX_LEVELS; j++) begin
                  if (below_mask[j]) begin
                     nz_in[j] = |ofs_ff;
                  end
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_wv_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_write_data    = rsp_data_ff;
   assign rsp_last          = rsp_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // the divider never runs past the level limit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (level_ff < lim_eff))
      else $error("divider running at or beyond the level limit");

   // the table walk never passes the record's level
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (lvl_ff <= level_ff))
      else $error("table walk beyond record level");

   // a new item starts only when any pending result is the last of its item
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_valid) |-> rsp_last)
      else $error("new item accepted while earlier results are pending");

   // a result is only loaded while walking the table
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && rsp_valid_in) |-> (state_ff == S_EMIT))
      else $error("result loaded outside the table walk");

endmodule
